/* rtl/core/xcfd_pkg.sv */
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the XOR-checked frame deframer: frame
// marker bytes, store geometry, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package xcfd_pkg;

    // Frame marker bytes
    localparam logic [7:0] HEADER_BYTE = 8'hF0;
    localparam logic [7:0] FOOTER_BYTE = 8'hFE;

    // Circular byte store geometry
    localparam int STORE_DEPTH = 32;
    localparam int IDX_W       = 5;   // log2 of STORE_DEPTH
    localparam int CNT_W       = 6;   // holds 0..STORE_DEPTH

    // Smallest legal frame: header, length, check byte, footer
    localparam logic [7:0] MIN_LEN = 8'd4;

    // Read offset select, relative to the oldest queued byte
    typedef enum logic [2:0] {
        RD_ZERO,    // header position
        RD_ONE,     // length byte
        RD_LAST,    // footer position (len - 1)
        RD_CHECK,   // check byte position (len - 2)
        RD_CNT      // running byte counter
    } t_rd_sel;

    // Byte counter operation
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_ONE,
        CNT_INC
    } t_cnt_op;

    // Controller to datapath
    typedef struct packed {
        logic    push;       // store the accepted input word
        logic    drop_one;   // discard the oldest queued byte
        logic    drop_len;   // discard a whole frame
        logic    rd_en;      // read the store at the selected offset
        t_rd_sel rd_sel;
        logic    len_load;   // capture the length byte
        logic    chk_clear;
        logic    chk_acc;    // fold read data into the running XOR
        t_cnt_op cnt_op;
        logic    out_load;   // load the output register
        logic    out_err;    // output word is an error report
        logic    out_last;   // output word ends a frame
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic held_zero;
        logic held_lt2;
        logic held_lt_len;
        logic is_hdr;        // read data is a header byte
        logic is_ftr;        // read data is a footer byte
        logic len_ok;        // read data is a legal frame length
        logic chk_match;     // running XOR equals read data
        logic cnt_at_last;   // counter at len - 1
        logic cnt_at_sum;    // counter at len - 3, last byte the XOR covers
        logic out_free;      // output register can take a word this cycle
    } t_sts;

endpackage

/* rtl/core/xor_checked_frame_deframer.sv */
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Finds F0 / length / payload / XOR check / FE frames in a received byte
// stream, emits good frames whole with a last mark, reports bad checksums.
// ----------------------------------------------------------------------------
// The input stalls while the controller scans: bytes ahead of a header are
//   dropped one by one, a header with a bad length or footer is dropped, and a
//   whole frame has its XOR checksum walked, then goes out with a read state
//   and a load state per word (one load state for an error word), waiting
//   while the output stalls; one input word at a time.
// Synchronous active-low reset empties the queue and the output register.
module xor_checked_frame_deframer #(
    parameter int MAX_FRAME = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_is_last,
    output logic       o_status
);
    import xcfd_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;

    // Scan sequencer
    xcfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Store, checksum and output register
    xcfd_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (i_rx_byte),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_is_last    (o_is_last),
        .o_status     (o_status)
    );

    assign o_stall = busy;

endmodule

/* rtl/core/xcfd_dp.sv */
// ----------------------------------------------------------------------------
// xcfd_dp
// Deframer datapath: circular byte store with registered read, queue
// pointers, length and XOR checksum registers, byte counter, and the output
// register that decouples the result channel.
// ----------------------------------------------------------------------------
module xcfd_dp #(
    parameter int MAX_FRAME = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_rx_byte,
    input  xcfd_pkg::t_cmd  i_cmd,
    output xcfd_pkg::t_sts  o_sts,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_frame_byte,
    output logic            o_is_last,
    output logic            o_status
);
    import xcfd_pkg::*;

    // Largest length that can be accepted and held whole
    localparam int         LEN_MAX_I = (MAX_FRAME < STORE_DEPTH) ? MAX_FRAME : STORE_DEPTH;
    localparam logic [7:0] LEN_MAX   = 8'(LEN_MAX_I);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STORE_DEPTH);

    logic [7:0]       r_mem [STORE_DEPTH];
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0] r_held,   n_held;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic [7:0]       r_chk;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_status;

    logic [IDX_W-1:0] rd_off;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             out_free;

    // Read offset select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO:  rd_off = '0;
            RD_ONE:   rd_off = IDX_W'(1);
            RD_LAST:  rd_off = r_len[IDX_W-1:0] - IDX_W'(1);
            RD_CHECK: rd_off = r_len[IDX_W-1:0] - IDX_W'(2);
            RD_CNT:   rd_off = r_cnt[IDX_W-1:0];
            default:  rd_off = '0;
        endcase
    end

    assign rd_addr = r_rd_idx + rd_off;
    // When full, this lands on the oldest byte, which is dropped at once
    assign wr_addr = r_rd_idx + r_held[IDX_W-1:0];

    // Byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Queue pointer next state
    always_comb begin
        n_rd_idx = r_rd_idx;
        n_held   = r_held;
        if (i_cmd.push) begin
            if (r_held == FULL) begin
                n_rd_idx = r_rd_idx + IDX_W'(1);
            end else begin
                n_held = r_held + CNT_W'(1);
            end
        end else if (i_cmd.drop_one) begin
            n_rd_idx = r_rd_idx + IDX_W'(1);
            n_held   = r_held - CNT_W'(1);
        end else if (i_cmd.drop_len) begin
            n_rd_idx = r_rd_idx + r_len[IDX_W-1:0];
            n_held   = r_held - r_len;
        end
    end

    // Byte counter next state
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_HOLD:  n_cnt = r_cnt;
            CNT_CLEAR: n_cnt = '0;
            CNT_ONE:   n_cnt = CNT_W'(1);
            CNT_INC:   n_cnt = r_cnt + CNT_W'(1);
            default:   n_cnt = r_cnt;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_held   <= '0;
            r_cnt    <= '0;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_held   <= n_held;
            r_cnt    <= n_cnt;
        end
    end

    // Length and checksum registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.len_load) begin
            r_len <= r_rd_data[CNT_W-1:0];
        end
        if (i_cmd.chk_clear) begin
            r_chk <= '0;
        end else if (i_cmd.chk_acc) begin
            r_chk <= r_chk ^ r_rd_data;
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte   <= i_cmd.out_err ? 8'd0 : r_rd_data;
            r_out_last   <= i_cmd.out_err | i_cmd.out_last;
            r_out_status <= i_cmd.out_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_is_last    = r_out_last;
    assign o_status     = r_out_status;

    // Status back to the controller
    assign o_sts.held_zero   = (r_held == '0);
    assign o_sts.held_lt2    = (r_held < CNT_W'(2));
    assign o_sts.held_lt_len = (r_held < r_len);
    assign o_sts.is_hdr      = (r_rd_data == HEADER_BYTE);
    assign o_sts.is_ftr      = (r_rd_data == FOOTER_BYTE);
    assign o_sts.len_ok      = (r_rd_data >= MIN_LEN) && (r_rd_data <= LEN_MAX);
    assign o_sts.chk_match   = (r_chk == r_rd_data);
    assign o_sts.cnt_at_last = (r_cnt == r_len - CNT_W'(1));
    assign o_sts.cnt_at_sum  = (r_cnt == r_len - CNT_W'(3));
    assign o_sts.out_free    = out_free;

    // Queue occupancy never exceeds the store
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= FULL)
        else $error("byte count above store depth");

    // A frame is only released when it is fully queued
    a_drop_len_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop_len |-> (r_held >= r_len) && (r_len >= CNT_W'(4)))
        else $error("frame release beyond queued bytes");

    // A waiting output word is never overwritten
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten");

    // Accepted words only enter while no frame is being worked on
    a_push_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !i_cmd.rd_en && !i_cmd.out_load)
        else $error("input word stored during a scan");

endmodule

/* rtl/core/xcfd_ctrl.sv */
// ----------------------------------------------------------------------------
// xcfd_ctrl
// Deframer controller: after each stored word, scans the queue for a header,
// validates length and footer, walks the XOR checksum, then emits the frame
// word by word or a single error word, and rescans.
// ----------------------------------------------------------------------------
module xcfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_busy,
    output xcfd_pkg::t_cmd  o_cmd,
    input  xcfd_pkg::t_sts  i_sts
);
    import xcfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR_RD,
        S_HDR_CHK,
        S_LEN_RD,
        S_LEN_CHK,
        S_FTR_RD,
        S_FTR_CHK,
        S_SUM_RD,
        S_SUM_ACC,
        S_CMP_RD,
        S_CMP,
        S_ERR,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.rd_sel    = RD_ZERO;
        o_cmd.cnt_op    = CNT_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_HDR_RD;
                end
            end
            // hunt for a header byte
            S_HDR_RD: begin
                if (i_sts.held_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ZERO;
                    n_state      = S_HDR_CHK;
                end
            end
            S_HDR_CHK: begin
                if (i_sts.is_hdr) begin
                    n_state = S_LEN_RD;
                end else begin
                    o_cmd.drop_one = 1'b1;
                    n_state        = S_HDR_RD;
                end
            end
            // length byte
            S_LEN_RD: begin
                if (i_sts.held_lt2) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ONE;
                    n_state      = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                if (i_sts.len_ok) begin
                    o_cmd.len_load = 1'b1;
                    n_state        = S_FTR_RD;
                end else begin
                    o_cmd.drop_one = 1'b1;
                    n_state        = S_HDR_RD;
                end
            end
            // footer, once the whole frame is queued
            S_FTR_RD: begin
                if (i_sts.held_lt_len) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                    n_state      = S_FTR_CHK;
                end
            end
            S_FTR_CHK: begin
                if (i_sts.is_ftr) begin
                    o_cmd.chk_clear = 1'b1;
                    o_cmd.cnt_op    = CNT_ONE;
                    n_state         = S_SUM_RD;
                end else begin
                    o_cmd.drop_one = 1'b1;
                    n_state        = S_HDR_RD;
                end
            end
            // XOR over length and payload bytes
            S_SUM_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CNT;
                n_state      = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.chk_acc = 1'b1;
                if (i_sts.cnt_at_sum) begin
                    n_state = S_CMP_RD;
                end else begin
                    o_cmd.cnt_op = CNT_INC;
                    n_state      = S_SUM_RD;
                end
            end
            S_CMP_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CHECK;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (i_sts.chk_match) begin
                    o_cmd.cnt_op = CNT_CLEAR;
                    n_state      = S_EMIT_RD;
                end else begin
                    n_state = S_ERR;
                end
            end
            // checksum mismatch: one error word, frame consumed
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    o_cmd.drop_len = 1'b1;
                    n_state        = S_HDR_RD;
                end
            end
            // good frame: header through footer
            S_EMIT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CNT;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = i_sts.cnt_at_last;
                    if (i_sts.cnt_at_last) begin
                        o_cmd.drop_len = 1'b1;
                        n_state        = S_HDR_RD;
                    end else begin
                        o_cmd.cnt_op = CNT_INC;
                        n_state      = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

    // Busy flag tracks the state register
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");

    // Every stored word starts a scan
    a_push_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> (r_state == S_HDR_RD))
        else $error("stored word not followed by a scan");

    // A frame is released only from an output step
    a_release_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drop_len |-> o_cmd.out_load && o_cmd.out_last | o_cmd.out_err)
        else $error("frame released without its closing word");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XOR-checked frame deframer. Byte words go in
// through a valid/stall channel with random gaps. A byte-queue predictor
// derives the frame and error words each input should produce. A monitor
// compares every output word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xcfd_pkg::*;

    localparam int FRAME_MAX = 32;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
        logic       status;
    } t_frame_word;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_frame_byte;
    logic       o_is_last;
    logic       o_status;

    t_frame_word expected_words[$];   // predicted output words, oldest first
    logic [7:0]  rx_backlog[$];       // predictor copy of the queued bytes
    int          error_count = 0;
    int          words_sent  = 0;
    bit          steady_flow = 1'b0;  // no gaps and no stalls while set

    xor_checked_frame_deframer #(
        .MAX_FRAME(FRAME_MAX)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_frame_byte(o_frame_byte),
        .o_is_last   (o_is_last),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    // Queue one byte and pull out every frame it completes
    function automatic void deframe_word(input logic [7:0] rx);
        int          flen;
        int          k;
        logic [7:0]  chk;
        t_frame_word w;
        if (rx_backlog.size() >= STORE_DEPTH) void'(rx_backlog.pop_front());
        rx_backlog.push_back(rx);
        while (1'b1) begin
            // anything ahead of a header is line noise
            while (rx_backlog.size() > 0 && rx_backlog[0] != HEADER_BYTE) begin
                void'(rx_backlog.pop_front());
            end
            if (rx_backlog.size() < 2) break;
            flen = rx_backlog[1];
            if (flen < MIN_LEN || flen > FRAME_MAX || flen > STORE_DEPTH) begin
                void'(rx_backlog.pop_front());
                continue;
            end
            if (rx_backlog.size() < flen) break;
            if (rx_backlog[flen - 1] != FOOTER_BYTE) begin
                void'(rx_backlog.pop_front());
                continue;
            end
            // check byte covers the length and payload bytes
            chk = 8'h00;
            for (k = 1; k < flen - 2; k++) chk ^= rx_backlog[k];
            if (chk == rx_backlog[flen - 2]) begin
                for (k = 0; k < flen; k++) begin
                    w.frame_byte = rx_backlog[k];
                    w.is_last    = (k == flen - 1);
                    w.status     = 1'b0;
                    expected_words.push_back(w);
                end
            end else begin
                w.frame_byte = 8'h00;
                w.is_last    = 1'b1;
                w.status     = 1'b1;
                expected_words.push_back(w);
            end
            repeat (flen) void'(rx_backlog.pop_front());
        end
    endfunction

    // Offer one word, with a random gap ahead of it, and wait for acceptance.
    // Valid is left high on return so back-to-back words need no toggle.
    task automatic send_word(input logic [7:0] b);
        if (!steady_flow) begin
            while ($urandom_range(99) < 35) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        deframe_word(b);
        words_sent++;
    endtask

    // Mostly well-formed frames with random content, plus broken ones and noise
    task automatic send_random_sequence();
        int         pick;
        int         flen;
        int         k;
        logic [7:0] chk;
        logic [7:0] p;
        pick = $urandom_range(99);
        if (pick >= 85) begin
            repeat ($urandom_range(6, 1)) send_word(8'($urandom));
            return;
        end
        if (pick >= 78) begin
            // impossible length: too short or beyond the limit
            flen = $urandom_range(1) ? int'($urandom_range(3))
                                     : int'($urandom_range(255, FRAME_MAX + 1));
            send_word(HEADER_BYTE);
            send_word(8'(flen));
            repeat ($urandom_range(3)) send_word(8'($urandom));
            return;
        end
        // most frames short, a few up to the maximum
        flen = ($urandom_range(9) == 0) ? int'($urandom_range(FRAME_MAX, 13))
                                        : int'($urandom_range(12, MIN_LEN));
        chk = 8'(flen);
        send_word(HEADER_BYTE);
        send_word(8'(flen));
        for (k = 2; k < flen - 2; k++) begin
            p = 8'($urandom);
            chk ^= p;
            send_word(p);
        end
        if (pick >= 60 && pick < 70) send_word(chk ^ 8'($urandom_range(255, 1)));
        else send_word(chk);
        if (pick >= 70) begin
            p = 8'($urandom);
            if (p == FOOTER_BYTE) p = 8'h00;
            send_word(p);
        end else begin
            send_word(FOOTER_BYTE);
        end
    endtask

    // Line noise, minimum frame, bad lengths and a checksum error
    task automatic test_marker_cases();
        send_word(8'hFF);
        send_word(8'h00);
        // shortest frame: check byte is the length alone
        send_word(HEADER_BYTE);
        send_word(MIN_LEN);
        send_word(MIN_LEN);
        send_word(FOOTER_BYTE);
        send_word(HEADER_BYTE);
        send_word(8'h03);
        send_word(HEADER_BYTE);
        send_word(8'(FRAME_MAX + 1));
        send_word(HEADER_BYTE);
        send_word(8'h05);
        send_word(8'hAA);
        send_word(8'h00);
        send_word(FOOTER_BYTE);
    endtask

    // A header read as a length, then an outer frame with no footer that
    // hides two complete frames; the final word releases both at once
    task automatic test_stacked_frames();
        send_word(HEADER_BYTE);
        send_word(HEADER_BYTE);
        send_word(8'h0B);
        repeat (2) begin
            send_word(HEADER_BYTE);
            send_word(MIN_LEN);
            send_word(MIN_LEN);
            send_word(FOOTER_BYTE);
        end
        send_word(8'h00);
    endtask

    task automatic test_random_traffic(input int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words) send_random_sequence();
    endtask

    // Input held off until the output side has caught up completely
    task automatic test_drain_pause();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_no_idle_burst(input int n_words);
        steady_flow = 1'b1;
        test_random_traffic(n_words);
        steady_flow = 1'b0;
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= !steady_flow && ($urandom_range(99) < 35);
    end

    // Output checker
    always @(posedge i_clk) begin : word_check
        t_frame_word w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                log_failure($sformatf("unexpected word byte=%02h last=%0b status=%0b",
                                      o_frame_byte, o_is_last, o_status));
            end else begin
                w = expected_words.pop_front();
                if (o_frame_byte !== w.frame_byte || o_is_last !== w.is_last ||
                    o_status !== w.status) begin
                    log_failure($sformatf(
                        "exp byte=%02h last=%0b status=%0b, got byte=%02h last=%0b status=%0b",
                        w.frame_byte, w.is_last, w.status,
                        o_frame_byte, o_is_last, o_status));
                end
            end
        end
    end

    initial begin : watchdog
        #(5_000_000);
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_marker_cases();
        test_stacked_frames();
        test_random_traffic(100);
        test_drain_pause();
        test_no_idle_burst(50);
        test_random_traffic(80);

        // let the last frames drain, then watch for stray words
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            log_failure($sformatf("%0d expected words never arrived", expected_words.size()));
        end
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
